[hw/rtl/dbrle_pkg.sv]
// Shared constants and types for the DCT block run-length encoder.
package dbrle_pkg;

	localparam int unsigned BLOCK_COEFFICIENTS_DEFAULT = 64;

	localparam int unsigned COEF_W     = 16;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned ZZ_W       = COEF_W + 1;
	localparam int unsigned MAX_BYTES  = 5;
	localparam int unsigned CNT_W      = 3;

	localparam logic [BYTE_W-1:0] EOB_BYTE      = 8'hFF;
	localparam logic              CONTINUE_FLAG = 1'b1;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [CNT_W-1:0]  cnt_t;

endpackage

[hw/rtl/dct_block_run_length_encoder_unit.sv]
// Top level of the DCT block run-length encoder: DC delta, AC run bytes and zigzag varints.
//
//   channel  | dir | tdata                      | tlast        | meaning
//   s_axis   | in  | [15:0] coefficient         | -            | one zigzag-ordered coefficient
//   m_axis   | out | [7:0]  out_byte            | last_of_item | one byte of the coded stream
//
// An accepted coefficient is held in the input register; its whole byte group
// (zero to five bytes) is then built in one pass and loaded into the output buffer.
// The buffer sends one byte per cycle while m_axis is ready; an item with no byte skips it,
// and a group loads as the last byte before it leaves.
// Reset clears the block position, the zero run, the previous DC and all valid flags.
// An m_axis stall holds the buffer, and the input register and s_axis if bytes are due.
module dct_block_run_length_encoder_unit
	import dbrle_pkg::*;
#(
	parameter int unsigned BLOCK_COEFFICIENTS = BLOCK_COEFFICIENTS_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [COEF_W-1:0] s_axis_tdata,   // [15:0] coefficient
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [BYTE_W-1:0] m_axis_tdata,   // [7:0] out_byte
	output logic              m_axis_tlast
);

	localparam int unsigned IDX_W = (BLOCK_COEFFICIENTS > 1) ? $clog2(BLOCK_COEFFICIENTS) : 1;

	// Block state.
	logic        [IDX_W-1:0]  idx_q;
	logic        [IDX_W-1:0]  run_q;
	logic signed [COEF_W-1:0] prev_dc_q;

	// Input register.
	logic                     valid_s1;
	logic signed [COEF_W-1:0] coef_s1;

	// Output buffer holding the byte group of one coefficient.
	logic  valid_s2;
	byte_t bytes_s2 [MAX_BYTES];
	cnt_t  cnt_s2;
	cnt_t  pos_s2;

	// Byte group construction.
	logic              dc_sel;
	logic              ac_nz;
	logic              emit_var;
	logic              is_last;
	logic signed [ZZ_W-1:0] diff;
	logic        [ZZ_W-1:0] zz;
	cnt_t              var_len;
	byte_t             vb0, vb1, vb2;
	byte_t             grp_bytes [MAX_BYTES];
	cnt_t              grp_cnt;

	logic out_xfer;
	logic out_done;
	logic buf_free;
	logic s1_advance;

	assign dc_sel  = (idx_q == '0);
	assign ac_nz   = !dc_sel && (coef_s1 != '0);
	assign emit_var = dc_sel || ac_nz;
	assign is_last = (idx_q == IDX_W'(BLOCK_COEFFICIENTS - 1));

	// The DC value is coded against the previous block's DC; AC values are coded as they are.
	assign diff = dc_sel ? (ZZ_W'(coef_s1) - ZZ_W'(prev_dc_q)) : ZZ_W'(coef_s1);

	// Zigzag map: shift left by one and flip every bit of a negative value.
	assign zz = {diff[ZZ_W-2:0], 1'b0} ^ {ZZ_W{diff[ZZ_W-1]}};

	always_comb begin
		if (zz[ZZ_W-1:14] != '0) begin
			var_len = cnt_t'(3);
		end else if (zz[13:7] != '0) begin
			var_len = cnt_t'(2);
		end else begin
			var_len = cnt_t'(1);
		end
	end

	// Seven bits per byte, low group first, continuation flag on all but the final byte.
	assign vb0 = {(var_len > cnt_t'(1)) ? CONTINUE_FLAG : 1'b0, zz[6:0]};
	assign vb1 = {(var_len > cnt_t'(2)) ? CONTINUE_FLAG : 1'b0, zz[13:7]};
	assign vb2 = BYTE_W'(zz[ZZ_W-1:14]);

	// Lay out run byte, varint bytes and end marker one after another.
	always_comb begin
		for (int i = 0; i < MAX_BYTES; i++) begin
			grp_bytes[i] = '0;
		end
		grp_cnt = '0;
		if (ac_nz) begin
			grp_bytes[0] = BYTE_W'(run_q);
			grp_cnt      = cnt_t'(1);
		end
		if (emit_var) begin
			grp_bytes[grp_cnt] = vb0;
			if (var_len > cnt_t'(1)) begin
				grp_bytes[grp_cnt + cnt_t'(1)] = vb1;
			end
			if (var_len > cnt_t'(2)) begin
				grp_bytes[grp_cnt + cnt_t'(2)] = vb2;
			end
			grp_cnt = grp_cnt + var_len;
		end
		if (is_last) begin
			grp_bytes[grp_cnt] = EOB_BYTE;
			grp_cnt            = grp_cnt + cnt_t'(1);
		end
	end

	// Handshake. A group that makes no byte never waits for the buffer.
	assign out_xfer   = m_axis_tvalid && m_axis_tready;
	assign out_done   = out_xfer && m_axis_tlast;
	assign buf_free   = !valid_s2 || out_done;
	assign s1_advance = valid_s1 && ((grp_cnt == '0) || buf_free);
	assign s_axis_tready = !valid_s1 || s1_advance;

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = bytes_s2[pos_s2];
	assign m_axis_tlast  = ((pos_s2 + cnt_t'(1)) == cnt_s2);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			coef_s1 <= s_axis_tdata;
		end
	end

	// Block state advances once per coefficient.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			run_q     <= '0;
			prev_dc_q <= '0;
		end else if (s1_advance) begin
			if (dc_sel) begin
				prev_dc_q <= coef_s1;
				run_q     <= '0;
			end else if (coef_s1 == '0) begin
				run_q <= run_q + IDX_W'(1);
			end else begin
				run_q <= '0;
			end
			if (is_last) begin
				idx_q <= '0;
				run_q <= '0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	// Output buffer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			pos_s2   <= '0;
		end else if (s1_advance && (grp_cnt != '0)) begin
			valid_s2 <= 1'b1;
			pos_s2   <= '0;
		end else if (out_done) begin
			valid_s2 <= 1'b0;
			pos_s2   <= '0;
		end else if (out_xfer) begin
			pos_s2 <= pos_s2 + cnt_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_advance && (grp_cnt != '0)) begin
			bytes_s2 <= grp_bytes;
			cnt_s2   <= grp_cnt;
		end
	end

`ifndef SYNTH
	// A buffered group always has its read position inside the group.
	a_pos_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (cnt_s2 != '0) && (pos_s2 < cnt_s2))
		else $error("output position outside the byte group");

	// The last coefficient of a block sends the position back to the DC slot.
	a_block_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_advance && is_last) |=> (idx_q == '0) && (run_q == '0))
		else $error("block position did not wrap after the last coefficient");

	// A zero run always stays below one less than the block length.
	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		run_q < IDX_W'(BLOCK_COEFFICIENTS - 1))
		else $error("zero run exceeds the block length");
`endif

endmodule

[bench/tb_dct_block_run_length_encoder_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the DCT block run-length encoder unit.
module tb_dct_block_run_length_encoder_unit
	import dbrle_pkg::*;
();

	// The unit is used with its default block size, so the longest zero run (62) is reachable.
	localparam int BLOCK_LEN    = BLOCK_COEFFICIENTS_DEFAULT;
	// Three whole blocks of random coefficients follow the three directed blocks.
	localparam int RANDOM_ITEMS = 192;
	// A correct unit keeps a transfer moving on one side or the other.
	// This bound covers five-byte groups, sink stalls and source gaps many times over.
	localparam int IDLE_LIMIT   = 2000;
	// The input register plus a full five-byte group, with margin for stray bytes.
	localparam int DRAIN_CYCLES = 12;

	// One byte of the coded stream together with its end-of-group flag.
	typedef struct packed {
		byte_t value;
		logic  last;
	} coded_byte_t;

	// Bytes typed in by hand for one coefficient, the first byte in the lowest bits.
	typedef struct packed {
		logic [2:0]  n;
		logic [39:0] bytes;
	} typed_group_t;

	// One line of the directed table: a coefficient, how often it is sent in a row,
	// and, where it can be read off directly, the bytes it has to produce.
	typedef struct packed {
		logic [COEF_W-1:0] coef;
		logic [6:0]        reps;
		typed_group_t      typed;
	} stim_row_t;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [COEF_W-1:0] s_axis_tdata;   // [15:0] coefficient
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [BYTE_W-1:0] m_axis_tdata;   // [7:0] out_byte
	logic              m_axis_tlast;

	dct_block_run_length_encoder_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// 100 MHz clock: five nanoseconds high, five low.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state: the DC of the previous block, where we are in the block, and the
	// zeros counted since the last nonzero AC coefficient.
	logic signed [COEF_W-1:0] prev_dc;
	int                       coef_pos;
	logic [5:0]               zero_count;

	// Bytes of the coefficient that is being coded right now.
	byte_t group_bytes [MAX_BYTES];
	int    group_len;

	coded_byte_t  expected_bytes [$];
	typed_group_t typed_groups [$];

	int mismatches;
	int coefs_accepted;
	int bytes_checked;
	int blocks_done;
	int idle_cycles;

	// While this is set, neither side inserts gaps or stalls.
	bit steady;

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("ERROR at %0t ns: %s", $time, msg);
	endtask

	// Appends one byte to the tail of the expected stream.
	task automatic expect_byte(input byte_t value, input logic last);
		coded_byte_t cb;
		cb.value = value;
		cb.last  = last;
		expected_bytes.insert(expected_bytes.size(), cb);
	endtask

	task automatic add_group_byte(input byte_t b);
		group_bytes[group_len] = b;
		group_len++;
	endtask

	// LEB128: seven bits per byte, low group first, continuation flag on all but the last.
	task automatic add_varint(input logic [ZZ_W-1:0] code);
		while (code >= ZZ_W'(128)) begin
			add_group_byte({CONTINUE_FLAG, code[6:0]});
			code = code >> 7;
		end
		add_group_byte({1'b0, code[6:0]});
	endtask

	// Zigzag map of a 17-bit signed value: doubled, and inverted when negative. The true
	// code never needs more than 17 bits, so the truncation loses nothing.
	function automatic logic [ZZ_W-1:0] zigzag_code(input logic signed [ZZ_W-1:0] v);
		return {v[ZZ_W-2:0], 1'b0} ^ {ZZ_W{v[ZZ_W-1]}};
	endfunction

	// Advances the predictor by one coefficient. When keep is set, the bytes it makes
	// are queued as the expectation; otherwise a typed-in group stands in their place.
	task automatic encode_coefficient(input logic [COEF_W-1:0] coef, input bit keep);
		logic signed [ZZ_W-1:0] delta;
		int                     i;
		group_len = 0;
		if (coef_pos == 0) begin
			// DC: difference from the last block's DC, both sign-extended to 17 bits.
			delta = {coef[COEF_W-1], coef} - {prev_dc[COEF_W-1], prev_dc};
			add_varint(zigzag_code(delta));
			prev_dc    = coef;
			zero_count = '0;
		end else if (coef == '0) begin
			// A zero AC coefficient only lengthens the run; it makes no byte.
			zero_count = zero_count + 6'd1;
		end else begin
			add_group_byte({2'b00, zero_count});
			add_varint(zigzag_code({coef[COEF_W-1], coef}));
			zero_count = '0;
		end
		if (coef_pos == BLOCK_LEN - 1) begin
			add_group_byte(EOB_BYTE);
			coef_pos   = 0;
			zero_count = '0;
			blocks_done++;
		end else begin
			coef_pos++;
		end
		if (keep) begin
			for (i = 0; i < group_len; i++)
				expect_byte(group_bytes[i], i == group_len - 1);
		end
	endtask

	// Everything is sampled at the rising edge, before the unit's registers move.
	// An accepted coefficient is predicted first; then an accepted byte is checked
	// against the oldest expectation. Input and output of one item can never meet
	// in the same edge, since the coefficient passes through the input register first.
	always @(posedge clk) begin : monitor
		typed_group_t tg;
		coded_byte_t  want;
		int           i;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				tg = '0;
				if (typed_groups.size() != 0)
					tg = typed_groups.pop_front();
				for (i = 0; i < tg.n; i++)
					expect_byte(tg.bytes[i*8 +: 8], i == tg.n - 1);
				encode_coefficient(s_axis_tdata, tg.n == 0);
				coefs_accepted++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_bytes.size() == 0) begin
					report_mismatch($sformatf("byte %02h (tlast %0b) arrived with nothing expected",
						m_axis_tdata, m_axis_tlast));
				end else begin
					want = expected_bytes.pop_front();
					if (m_axis_tdata !== want.value)
						report_mismatch($sformatf("out_byte %02h, expected %02h (byte %0d)",
							m_axis_tdata, want.value, bytes_checked));
					if (m_axis_tlast !== want.last)
						report_mismatch($sformatf("last_of_item %0b, expected %0b (byte %0d)",
							m_axis_tlast, want.last, bytes_checked));
				end
				bytes_checked++;
			end
		end
	end

	// Watchdog: counts cycles in which no transfer happens on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// The sink stalls with a ten percent chance at each falling edge, except during the steady stretch.
	always @(negedge clk)
		m_axis_tready <= steady || ($urandom_range(0, 99) >= 10);

	// Offers one coefficient and returns at the falling edge after its transfer.
	// Valid stays high from one coefficient to the next unless a gap is drawn.
	task automatic send_coefficient(input logic [COEF_W-1:0] coef, input typed_group_t tg);
		if (!steady && $urandom_range(0, 99) < 10) begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		typed_groups.insert(typed_groups.size(), tg);
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = coef;
		do
			@(posedge clk);
		while (!s_axis_tready);
		@(negedge clk);
	endtask

	// Mostly zeros, as in a quantized block, with small values, varint boundaries,
	// the 16-bit extremes and fully random words mixed in.
	function automatic logic [COEF_W-1:0] random_coefficient();
		logic [31:0]       r;
		logic [COEF_W-1:0] mag;
		int unsigned       sel;
		r   = $urandom();
		sel = $urandom_range(0, 9);
		if (sel inside {[0:4]})
			return '0;
		if (sel inside {[5:6]}) begin
			mag = COEF_W'($urandom_range(1, 200));
			return r[0] ? -mag : mag;
		end
		if (sel == 7) begin
			case ($urandom_range(0, 7))
				0: return 16'h7FFF;
				1: return 16'h8000;
				2: return 16'h0001;
				3: return 16'hFFFF;
				4: return 16'h003F;
				5: return 16'h0040;
				6: return 16'hFFC0;
				default: return 16'hFFBF;
			endcase
		end
		return r[COEF_W-1:0];
	endfunction

	stim_row_t stim_rows [$];

	task automatic add_row(input logic [COEF_W-1:0] coef, input int reps,
			input int n, input logic [39:0] bytes);
		stim_row_t row;
		row.coef        = coef;
		row.reps        = 7'(reps);
		row.typed.n     = 3'(n);
		row.typed.bytes = bytes;
		stim_rows.insert(stim_rows.size(), row);
	endtask

	initial begin : stimulus
		int r;
		int k;
		clk            = 1'b0;
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		m_axis_tready  = 1'b0;
		steady         = 1'b0;
		prev_dc        = '0;
		coef_pos       = 0;
		zero_count     = '0;
		group_len      = 0;
		mismatches     = 0;
		coefs_accepted = 0;
		bytes_checked  = 0;
		blocks_done    = 0;
		idle_cycles    = 0;

		// Directed table: three whole blocks. Typed groups list bytes first-lowest.
		// Block one, starting from a previous DC of zero.
		add_row(16'h0000, 1, 1, 40'h00_0000_0000);  // DC with zero difference: 00
		add_row(16'h0001, 1, 2, 40'h00_0000_0200);  // +1 with no run: 00 02
		add_row(16'hFFFF, 1, 2, 40'h00_0000_0100);  // -1 with no run: 00 01
		add_row(16'h7FFF, 1, 4, 40'h00_03FF_FE00);  // largest AC: 00 FE FF 03
		add_row(16'h8000, 1, 4, 40'h00_03FF_FF00);  // smallest AC: 00 FF FF 03
		add_row(16'h003F, 1, 0, '0);                // largest one-byte varint
		add_row(16'h0040, 1, 0, '0);                // smallest two-byte varint
		add_row(16'h0000, 5, 0, '0);
		add_row(16'hFFC0, 1, 0, '0);                // run of five, one-byte varint
		add_row(16'hFFBF, 1, 0, '0);                // negative two-byte varint
		add_row(16'h0000, 49, 0, '0);
		add_row(16'h7FFF, 1, 0, '0);                // nonzero last: five bytes
		// Block two: a large positive DC step, then nothing but zeros.
		add_row(16'h7FFF, 1, 0, '0);
		add_row(16'h0000, 62, 0, '0);
		add_row(16'h0000, 1, 1, 40'h00_0000_00FF);  // zero last coefficient: only FF
		// Block three: the largest negative DC step, then the longest possible run.
		add_row(16'h8000, 1, 0, '0);
		add_row(16'h0000, 62, 0, '0);
		add_row(16'hFFFF, 1, 0, '0);

		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (stim_rows[i])
			for (k = 0; k < stim_rows[i].reps; k++)
				send_coefficient(stim_rows[i].coef, stim_rows[i].typed);

		// Random blocks; the middle third runs with no gaps and no stalls at all.
		for (r = 0; r < RANDOM_ITEMS; r++) begin
			steady = (r >= RANDOM_ITEMS / 3) && (r < 2 * RANDOM_ITEMS / 3);
			send_coefficient(random_coefficient(), '0);
		end
		steady        = 1'b0;
		s_axis_tvalid = 1'b0;

		// Drain, then give the unit time to show any byte it should not send.
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d coefficients in %0d blocks, %0d coded bytes compared.",
			coefs_accepted, blocks_done, bytes_checked);
		$display("Included DC and AC extremes, varint boundaries, runs up to 62, stalls.");
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
